### src/tse_pkg.sv
// Shared types and constants for the TLS server-name extractor.
package tse_pkg;

	// Protocol constants
	localparam logic [7:0]  TLS_HANDSHAKE   = 8'h16;
	localparam logic [7:0]  TLS_MAJOR       = 8'h03;
	localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
	localparam int unsigned RANDOM_LEN      = 32;
	// Session id length byte follows record header, handshake header, version and random
	localparam logic [17:0] SID_POS         = 18'(9 + 2 + RANDOM_LEN);

	// Configuration port
	localparam int unsigned ADDR_W         = 3;
	localparam logic        REG_NAME_LIMIT = 1'b0;
	localparam logic [7:0]  NAME_LIMIT_RST = 8'd255;

	// Result kinds
	localparam logic KIND_NAME    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Output queue
	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        packet_first;
		logic [15:0] payload_length;
	} in_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] name_byte;
		logic       name_last;
		logic       host_found;
		logic       hello_seen;
		logic [7:0] name_length;
	} out_item_t;

	// Up to two results per input beat; vld1 only ever set together with vld0
	typedef struct packed {
		logic      vld0;
		logic      vld1;
		out_item_t res0;
		out_item_t res1;
	} tse_push_t;

endpackage

### src/tse_parser.sv
// Byte-wise ClientHello parser: state update and result forming for one beat.
module tse_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  tse_pkg::in_item_t item,
	input  logic [7:0]       name_limit,
	output tse_pkg::tse_push_t push
);
	import tse_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE, PH_DRAIN, PH_REC_TYPE, PH_REC_VER, PH_REC_LEN, PH_HS_TYPE,
		PH_HS_LEN, PH_SID_LEN, PH_CS_LEN, PH_CM_LEN, PH_EXTS_LEN, PH_EXT_TYPE,
		PH_EXT_LEN_SNI, PH_EXT_LEN_OTHER, PH_LIST_LEN, PH_ENTRY_TYPE,
		PH_ENTRY_LEN_HOST, PH_ENTRY_LEN_OTHER, PH_NAME
	} phase_t;

	// Parser state
	phase_t      phase_q;
	logic [15:0] idx_q, total_q;
	logic [23:0] acc_q;
	logic [1:0]  fbl_q;
	logic [16:0] skip_q, hello_end_q, ext_end_q, sn_end_q;
	logic [7:0]  nbl_q, emit_q;
	logic        found_q;
	logic [1:0]  marks_q;

	// State as seen by this beat (after a restart) and next state
	phase_t      c_phase, n_phase;
	logic [15:0] c_idx, c_total, n_idx, n_total;
	logic [23:0] c_acc, n_acc;
	logic [1:0]  c_fbl, n_fbl;
	logic [16:0] c_skip, c_hello_end, c_ext_end, c_sn_end;
	logic [16:0] n_skip, n_hello_end, n_ext_end, n_sn_end;
	logic [7:0]  c_nbl, c_emit, n_nbl, n_emit;
	logic        c_found, n_found;
	logic [1:0]  c_marks, n_marks;

	// Field completion working signals
	logic        zero_verdict, name_vld, verdict_vld, name_last_c, last_byte;
	logic [23:0] v;
	logic [16:0] p;
	logic [17:0] pv;
	logic [24:0] hs_end;
	logic        go_c, fail_c, direct_c, alt_c, begin_ok, alt_ok;
	logic [17:0] pos_c;
	logic [2:0]  chk_c;
	logic [1:0]  fw_c;
	logic [16:0] end_c;
	phase_t      ph_c;
	logic [7:0]  n_len;
	out_item_t   name_res, verdict_res;

	always_comb begin
		zero_verdict = item.packet_first && (item.payload_length == 16'd0);
		// A first byte restarts parsing from a clean slate
		if (item.packet_first) begin
			c_phase     = zero_verdict ? PH_IDLE : PH_REC_TYPE;
			c_idx       = '0;
			c_total     = item.payload_length;
			c_acc       = '0;
			c_fbl       = 2'd1;
			c_skip      = '0;
			c_hello_end = '0;
			c_ext_end   = '0;
			c_sn_end    = '0;
			c_nbl       = '0;
			c_emit      = '0;
			c_found     = 1'b0;
			c_marks     = '0;
		end else begin
			c_phase     = phase_q;
			c_idx       = idx_q;
			c_total     = total_q;
			c_acc       = acc_q;
			c_fbl       = fbl_q;
			c_skip      = skip_q;
			c_hello_end = hello_end_q;
			c_ext_end   = ext_end_q;
			c_sn_end    = sn_end_q;
			c_nbl       = nbl_q;
			c_emit      = emit_q;
			c_found     = found_q;
			c_marks     = marks_q;
		end

		n_phase     = c_phase;
		n_idx       = c_idx;
		n_total     = c_total;
		n_acc       = c_acc;
		n_fbl       = c_fbl;
		n_skip      = c_skip;
		n_hello_end = c_hello_end;
		n_ext_end   = c_ext_end;
		n_sn_end    = c_sn_end;
		n_nbl       = c_nbl;
		n_emit      = c_emit;
		n_found     = c_found;
		n_marks     = c_marks;

		name_vld    = 1'b0;
		verdict_vld = 1'b0;
		name_last_c = 1'b0;

		v      = {c_acc[15:0], item.data_byte};
		p      = {1'b0, c_idx} + 17'd1;
		pv     = {1'b0, p} + {2'b0, v[15:0]};
		hs_end = {1'b0, v} + 25'd9;
		last_byte = (p >= {1'b0, c_total});

		go_c     = 1'b0;
		fail_c   = 1'b0;
		direct_c = 1'b0;
		alt_c    = 1'b0;
		pos_c    = '0;
		chk_c    = '0;
		fw_c     = '0;
		end_c    = '0;
		ph_c     = PH_DRAIN;
		n_len    = '0;
		begin_ok = 1'b0;
		alt_ok   = 1'b0;

		if (zero_verdict) begin
			verdict_vld = 1'b1;
		end else if (c_phase != PH_IDLE) begin
			// ClientHello signature marks
			if (c_idx == 16'd0 && item.data_byte == TLS_HANDSHAKE)
				n_marks[0] = 1'b1;
			if (c_idx == 16'd5 && item.data_byte == HS_CLIENT_HELLO)
				n_marks[1] = 1'b1;

			if (c_phase == PH_NAME) begin
				// Host name bytes
				if ({1'b0, c_idx} >= c_skip) begin
					n_nbl       = c_nbl - 8'd1;
					n_emit      = c_emit + 8'd1;
					name_vld    = 1'b1;
					name_last_c = (n_nbl == 8'd0);
					if (name_last_c)
						n_phase = PH_DRAIN;
				end
			end else if (c_phase != PH_DRAIN) begin
				// Field gathering
				if ({1'b0, c_idx} >= c_skip && c_fbl != 2'd0) begin
					n_acc = v;
					n_fbl = c_fbl - 2'd1;
					go_c  = (n_fbl == 2'd0);
				end
			end

			if (go_c) begin
				// Field complete: check it and pick the next field
				case (c_phase)
					PH_REC_TYPE: begin
						fail_c = (c_total < 16'd5) || (v != 24'(TLS_HANDSHAKE));
						ph_c = PH_REC_VER; pos_c = 18'd1; chk_c = 3'd1; fw_c = 2'd1;
						end_c = {1'b0, c_total};
					end
					PH_REC_VER: begin
						fail_c = (v != 24'(TLS_MAJOR));
						ph_c = PH_REC_LEN; pos_c = 18'd3; chk_c = 3'd2; fw_c = 2'd2;
						end_c = {1'b0, c_total};
					end
					PH_REC_LEN: begin
						fail_c = (v == 24'd0)
							|| ({1'b0, c_total} < ({1'b0, v[15:0]} + 17'd5))
							|| (c_total < 16'd9);
						ph_c = PH_HS_TYPE; pos_c = 18'd5; chk_c = 3'd1; fw_c = 2'd1;
						end_c = {1'b0, c_total};
					end
					PH_HS_TYPE: begin
						fail_c = (v != 24'(HS_CLIENT_HELLO));
						ph_c = PH_HS_LEN; pos_c = 18'd6; chk_c = 3'd3; fw_c = 2'd3;
						end_c = {1'b0, c_total};
					end
					PH_HS_LEN: begin
						fail_c = (v == 24'd0) || ({9'b0, c_total} < hs_end);
						if (!fail_c)
							n_hello_end = hs_end[16:0];
						ph_c = PH_SID_LEN; pos_c = SID_POS; chk_c = 3'd1; fw_c = 2'd1;
						end_c = hs_end[16:0];
					end
					PH_SID_LEN: begin
						fail_c = (pv > {1'b0, c_hello_end});
						ph_c = PH_CS_LEN; pos_c = pv; chk_c = 3'd2; fw_c = 2'd2;
						end_c = c_hello_end;
					end
					PH_CS_LEN: begin
						fail_c = (pv > {1'b0, c_hello_end});
						ph_c = PH_CM_LEN; pos_c = pv; chk_c = 3'd1; fw_c = 2'd1;
						end_c = c_hello_end;
					end
					PH_CM_LEN: begin
						fail_c = (pv > {1'b0, c_hello_end});
						ph_c = PH_EXTS_LEN; pos_c = pv; chk_c = 3'd2; fw_c = 2'd2;
						end_c = c_hello_end;
					end
					PH_EXTS_LEN: begin
						fail_c = (pv > {1'b0, c_hello_end});
						if (!fail_c)
							n_ext_end = pv[16:0];
						// need room for a whole extension header
						ph_c = PH_EXT_TYPE; pos_c = {1'b0, p}; chk_c = 3'd4; fw_c = 2'd2;
						end_c = pv[16:0];
					end
					PH_EXT_TYPE: begin
						ph_c = (v[15:0] == 16'h0000) ? PH_EXT_LEN_SNI : PH_EXT_LEN_OTHER;
						pos_c = {1'b0, p}; chk_c = 3'd2; fw_c = 2'd2;
						end_c = c_ext_end;
					end
					PH_EXT_LEN_SNI: begin
						fail_c = (pv > {1'b0, c_ext_end});
						if (!fail_c)
							n_sn_end = pv[16:0];
						ph_c = PH_LIST_LEN; pos_c = {1'b0, p}; chk_c = 3'd2; fw_c = 2'd2;
						end_c = pv[16:0];
					end
					PH_EXT_LEN_OTHER: begin
						fail_c = (pv > {1'b0, c_ext_end});
						ph_c = PH_EXT_TYPE; pos_c = pv; chk_c = 3'd4; fw_c = 2'd2;
						end_c = c_ext_end;
					end
					PH_LIST_LEN: begin
						fail_c = (pv > {1'b0, c_sn_end});
						ph_c = PH_ENTRY_TYPE; pos_c = {1'b0, p}; chk_c = 3'd3; fw_c = 2'd1;
						end_c = c_sn_end; alt_c = 1'b1;
					end
					PH_ENTRY_TYPE: begin
						ph_c = (v[15:0] == 16'h0000) ? PH_ENTRY_LEN_HOST : PH_ENTRY_LEN_OTHER;
						pos_c = {1'b0, p}; chk_c = 3'd2; fw_c = 2'd2;
						end_c = c_sn_end;
					end
					PH_ENTRY_LEN_HOST: begin
						fail_c   = (pv > {1'b0, c_sn_end});
						direct_c = 1'b1;
						if (!fail_c) begin
							n_found = 1'b1;
							n_len   = (v[15:0] > {8'b0, name_limit}) ? name_limit : v[7:0];
							n_nbl   = n_len;
							n_emit  = '0;
							if (n_len == 8'd0) begin
								n_phase = PH_DRAIN;
							end else begin
								n_phase = PH_NAME;
								n_skip  = p;
							end
						end
					end
					PH_ENTRY_LEN_OTHER: begin
						fail_c = (pv > {1'b0, c_sn_end});
						ph_c = PH_ENTRY_TYPE; pos_c = pv; chk_c = 3'd3; fw_c = 2'd1;
						end_c = c_sn_end; alt_c = 1'b1;
					end
					default: begin
						direct_c = 1'b1;
						n_phase  = PH_DRAIN;
					end
				endcase

				// Start the next field if it fits, else fall back or give up
				begin_ok = ({1'b0, pos_c} + {16'b0, chk_c}) <= {2'b0, end_c};
				alt_ok   = ({1'b0, c_sn_end} + 18'd4) <= {1'b0, c_ext_end};
				if (fail_c) begin
					n_phase = PH_DRAIN;
				end else if (!direct_c) begin
					if (begin_ok) begin
						n_phase = ph_c;
						n_skip  = pos_c[16:0];
						n_fbl   = fw_c;
						n_acc   = '0;
					end else if (alt_c && alt_ok) begin
						n_phase = PH_EXT_TYPE;
						n_skip  = c_sn_end;
						n_fbl   = 2'd2;
						n_acc   = '0;
					end else begin
						n_phase = PH_DRAIN;
					end
				end
			end

			// End of payload
			if (last_byte) begin
				verdict_vld = 1'b1;
				n_phase     = PH_IDLE;
			end else begin
				n_idx = p[15:0];
			end
		end

		// Result forming
		name_res             = '0;
		name_res.result_kind = KIND_NAME;
		name_res.name_byte   = item.data_byte;
		name_res.name_last   = name_last_c;

		verdict_res             = '0;
		verdict_res.result_kind = KIND_VERDICT;
		if (!zero_verdict) begin
			verdict_res.host_found  = n_found;
			verdict_res.hello_seen  = (c_total >= 16'd6) && (n_marks == 2'b11);
			verdict_res.name_length = n_emit;
		end

		push.vld0 = take && (name_vld || verdict_vld);
		push.vld1 = take && name_vld && verdict_vld;
		push.res0 = name_vld ? name_res : verdict_res;
		push.res1 = verdict_res;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			idx_q       <= '0;
			total_q     <= '0;
			acc_q       <= '0;
			fbl_q       <= '0;
			skip_q      <= '0;
			hello_end_q <= '0;
			ext_end_q   <= '0;
			sn_end_q    <= '0;
			nbl_q       <= '0;
			emit_q      <= '0;
			found_q     <= 1'b0;
			marks_q     <= '0;
		end else if (take) begin
			phase_q     <= n_phase;
			idx_q       <= n_idx;
			total_q     <= n_total;
			acc_q       <= n_acc;
			fbl_q       <= n_fbl;
			skip_q      <= n_skip;
			hello_end_q <= n_hello_end;
			ext_end_q   <= n_ext_end;
			sn_end_q    <= n_sn_end;
			nbl_q       <= n_nbl;
			emit_q      <= n_emit;
			found_q     <= n_found;
			marks_q     <= n_marks;
		end
	end

endmodule

### src/tse_out_queue.sv
// Small result queue: takes up to two results a cycle, hands out one a beat.
module tse_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  tse_pkg::tse_push_t  push,
	input  logic                out_stall,
	output logic                out_valid,
	output tse_pkg::out_item_t  out_data,
	output logic                room
);
	import tse_pkg::*;

	out_item_t             mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wr_q, rd_q;
	logic [OQ_CNT_W-1:0]   count_q;
	logic                  pop;
	logic [OQ_PTR_W-1:0]   wr_nx;

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;
	assign wr_nx     = wr_q + OQ_PTR_W'(1);
	// Room for a full pair of results
	assign room      = (count_q <= OQ_CNT_W'(OQ_DEPTH - 2));

	// Entry storage
	always_ff @(posedge clk) begin
		for (int k = 0; k < OQ_DEPTH; k++) begin
			if (push.vld0 && wr_q == OQ_PTR_W'(k))
				mem_q[k] <= push.res0;
			else if (push.vld1 && wr_nx == OQ_PTR_W'(k))
				mem_q[k] <= push.res1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + OQ_PTR_W'(push.vld0) + OQ_PTR_W'(push.vld1);
			rd_q    <= rd_q + OQ_PTR_W'(pop);
			count_q <= count_q + OQ_CNT_W'(push.vld0) + OQ_CNT_W'(push.vld1)
				- OQ_CNT_W'(pop);
		end
	end

endmodule

### src/tls_sni_extractor.sv
// Top level of the TLS ClientHello server-name extractor.
//
//  channel  | direction | handshake           | beat payload
//  ---------+-----------+---------------------+---------------------------------
//  in       | input     | in_valid / in_stall | in_data: byte, first mark, length
//  out      | output    | out_valid/out_stall | out_data: name byte or verdict
//  config   | input     | APB psel/penable    | name_limit at addresses 0-3
//
// One payload byte a cycle while in_stall is low: byte register, then parse
// logic into a four-entry result queue, which registers each result.
// The final byte of a payload may give a name byte and a verdict; the queue
// takes both at once and hands them out on successive beats.
// in_stall rises only while the byte register is full and the queue lacks room
// for two results. Reset clears all control state and sets name_limit to 255.
module tls_sni_extractor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  tse_pkg::in_item_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output tse_pkg::out_item_t           out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tse_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import tse_pkg::*;

	logic       valid_s1;
	in_item_t   item_s1;
	logic       room, take, accept;
	logic [7:0] name_limit_q;
	logic       reg_hit;
	tse_push_t  push;

	// Configuration register
	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1] == REG_NAME_LIMIT);
	assign prdata  = reg_hit ? {24'b0, name_limit_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			name_limit_q <= NAME_LIMIT_RST;
		else if (psel && penable && pwrite && reg_hit)
			name_limit_q <= pwdata[7:0];
	end

	// Input byte register
	assign take     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (take)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= in_data;
	end

	tse_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.item       (item_s1),
		.name_limit (name_limit_q),
		.push       (push)
	);

	tse_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.room      (room)
	);

endmodule

### tb/tls_sni_extractor_test.sv
// Self-checking testbench for the TLS ClientHello server-name extractor.
module tls_sni_extractor_test;
	import tse_pkg::*;

	localparam int unsigned RUN_LIMIT = 300000;
	localparam int unsigned SETTLE    = 8;
	localparam int unsigned HOLD_LEN  = 400;
	localparam int unsigned PHASE_MIN = 120;
	localparam logic [ADDR_W-1:0] LIMIT_ADDR = ADDR_W'(4 * REG_NAME_LIMIT);

	typedef logic [7:0] octets_t[$];

	typedef enum logic [4:0] {
		P_IDLE, P_DRAIN, P_REC_TYPE, P_REC_VER, P_REC_LEN, P_HS_TYPE, P_HS_LEN,
		P_SID_LEN, P_CS_LEN, P_CM_LEN, P_EXTS_LEN, P_EXT_TYPE, P_EXT_LEN_SNI,
		P_EXT_LEN_OTHER, P_LIST_LEN, P_ENTRY_TYPE, P_ENTRY_LEN_HOST,
		P_ENTRY_LEN_OTHER, P_NAME
	} hs_step_e;

	typedef enum logic [1:0] {ST_PENDING, ST_FOUND, ST_FAILED} sni_status_e;
	typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_pace_e;
	typedef enum logic [2:0] {
		DMG_BYTE, DMG_LENGTH, DMG_HS_HUGE, DMG_SHORT, DMG_LONG
	} damage_e;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic hold_req = 1'b0;

	tls_sni_extractor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shared bookkeeping
	in_item_t bytes_to_send[$];
	out_item_t results_due[$];
	int unsigned items_queued = 0;
	int unsigned items_accepted = 0;
	int unsigned phase_bytes = 0;
	int unsigned parsed_bytes = 0;
	int unsigned payloads_sent = 0;
	int unsigned names_seen = 0;
	int unsigned verdicts_seen = 0;
	int unsigned finds_seen = 0;
	int unsigned errors = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned seg_left = 0;
	int unsigned hold_left = 0;
	rx_pace_e rx_mode = RX_FLOW;

	// Parser mirror state
	logic [7:0]  limit_cfg;
	logic [15:0] pos_idx;
	logic [15:0] pay_len;
	hs_step_e    step;
	logic [23:0] acc;
	logic [1:0]  acc_left;
	logic [16:0] field_at;
	logic [16:0] hs_stop;
	logic [16:0] exts_end;
	logic [16:0] sni_end;
	logic [15:0] name_left;
	logic [7:0]  name_count;
	sni_status_e status;
	logic [1:0]  marks;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
		errors++;
	endtask

	// ---- parser mirror ----
	function automatic void clear_parse();
		pos_idx = '0; pay_len = '0; step = P_IDLE; acc = '0; acc_left = '0;
		field_at = '0; hs_stop = '0; exts_end = '0; sni_end = '0;
		name_left = '0; name_count = '0; status = ST_PENDING; marks = '0;
	endfunction

	function automatic void abandon();
		status = ST_FAILED;
		step = P_DRAIN;
	endfunction

	function automatic void open_field(input hs_step_e nxt, input int unsigned at,
			input int unsigned w, input int unsigned lim);
		if (at + w > lim) begin
			abandon();
		end else begin
			step = nxt;
			field_at = 17'(at);
			acc_left = 2'(w);
			acc = '0;
		end
	endfunction

	function automatic void next_ext(input int unsigned at);
		if (at + 4 <= exts_end) open_field(P_EXT_TYPE, at, 2, exts_end);
		else abandon();
	endfunction

	function automatic void next_entry(input int unsigned at);
		if (at + 3 <= sni_end) open_field(P_ENTRY_TYPE, at, 1, sni_end);
		else next_ext(sni_end);
	endfunction

	// p: position just past the finished field, v: its value
	function automatic void field_done(input int unsigned p, input int unsigned v);
		int unsigned n;
		case (step)
			P_REC_TYPE: begin
				if (pay_len < 5 || v != TLS_HANDSHAKE) abandon();
				else open_field(P_REC_VER, 1, 1, pay_len);
			end
			P_REC_VER: begin
				if (v != TLS_MAJOR) abandon();
				else open_field(P_REC_LEN, 3, 2, pay_len);
			end
			P_REC_LEN: begin
				if (v == 0 || pay_len < 5 + v || pay_len < 9) abandon();
				else open_field(P_HS_TYPE, 5, 1, pay_len);
			end
			P_HS_TYPE: begin
				if (v != HS_CLIENT_HELLO) abandon();
				else open_field(P_HS_LEN, 6, 3, pay_len);
			end
			P_HS_LEN: begin
				if (v == 0 || pay_len < 9 + v) begin
					abandon();
				end else begin
					hs_stop = 17'(9 + v);
					open_field(P_SID_LEN, SID_POS, 1, hs_stop);
				end
			end
			P_SID_LEN: begin
				if (p + v > hs_stop) abandon();
				else open_field(P_CS_LEN, p + v, 2, hs_stop);
			end
			P_CS_LEN: begin
				if (p + v > hs_stop) abandon();
				else open_field(P_CM_LEN, p + v, 1, hs_stop);
			end
			P_CM_LEN: begin
				if (p + v > hs_stop) abandon();
				else open_field(P_EXTS_LEN, p + v, 2, hs_stop);
			end
			P_EXTS_LEN: begin
				if (p + v > hs_stop) begin
					abandon();
				end else begin
					exts_end = 17'(p + v);
					next_ext(p);
				end
			end
			P_EXT_TYPE: open_field(v == 0 ? P_EXT_LEN_SNI : P_EXT_LEN_OTHER, p, 2, exts_end);
			P_EXT_LEN_SNI: begin
				if (p + v > exts_end) begin
					abandon();
				end else begin
					sni_end = 17'(p + v);
					open_field(P_LIST_LEN, p, 2, sni_end);
				end
			end
			P_EXT_LEN_OTHER: begin
				if (p + v > exts_end) abandon();
				else next_ext(p + v);
			end
			P_LIST_LEN: begin
				if (p + v > sni_end) abandon();
				else next_entry(p);
			end
			P_ENTRY_TYPE: open_field(v == 0 ? P_ENTRY_LEN_HOST : P_ENTRY_LEN_OTHER, p, 2, sni_end);
			P_ENTRY_LEN_HOST: begin
				if (p + v > sni_end) begin
					abandon();
				end else begin
					status = ST_FOUND;
					n = v;
					if (n > 255) n = 255;
					if (n > limit_cfg) n = limit_cfg;
					name_left = 16'(n);
					name_count = '0;
					if (n == 0) begin
						step = P_DRAIN;
					end else begin
						step = P_NAME;
						field_at = 17'(p);
					end
				end
			end
			P_ENTRY_LEN_OTHER: begin
				if (p + v > sni_end) abandon();
				else next_entry(p + v);
			end
			default: step = P_DRAIN;
		endcase
	endfunction

	// Advance the mirror by one accepted beat and queue what it must produce
	function automatic void track_hello_byte(input in_item_t it);
		int unsigned i;
		out_item_t r;
		logic [7:0] lim;
		if (it.packet_first) begin
			lim = limit_cfg;
			clear_parse();
			limit_cfg = lim;
			pay_len = it.payload_length;
			if (pay_len == 0) begin
				r = '0;
				r.result_kind = KIND_VERDICT;
				results_due.push_back(r);
				return;
			end
			step = P_REC_TYPE;
			acc_left = 2'd1;
		end
		if (step == P_IDLE) return;

		i = pos_idx;
		if (i == 0 && it.data_byte == TLS_HANDSHAKE) marks[0] = 1'b1;
		if (i == 5 && it.data_byte == HS_CLIENT_HELLO) marks[1] = 1'b1;

		if (step == P_NAME) begin
			if (i >= field_at) begin
				name_left--;
				name_count++;
				r = '0;
				r.result_kind = KIND_NAME;
				r.name_byte = it.data_byte;
				r.name_last = (name_left == 0);
				results_due.push_back(r);
				if (name_left == 0) step = P_DRAIN;
			end
		end else if (step != P_DRAIN) begin
			if (i >= field_at && acc_left != 0) begin
				acc = {acc[15:0], it.data_byte};
				acc_left--;
				if (acc_left == 0) field_done(i + 1, acc);
			end
		end

		if (i + 1 >= pay_len) begin
			r = '0;
			r.result_kind = KIND_VERDICT;
			r.host_found = (status == ST_FOUND);
			r.hello_seen = (pay_len >= 6 && marks == 2'b11);
			r.name_length = name_count;
			results_due.push_back(r);
			step = P_IDLE;
		end else begin
			pos_idx = 16'(i + 1);
		end
	endfunction

	// ---- sender: bursts with random gaps ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				track_hello_byte(in_data);
				items_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (bytes_to_send.size() != 0) begin
					in_data <= bytes_to_send.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 32);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---- receiver pacing, with a long hold-off on request ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			seg_left = 0;
			hold_left = 0;
			rx_mode = RX_FLOW;
		end else begin
			if (hold_req) hold_left = HOLD_LEN;
			if (seg_left == 0) begin
				seg_left = $urandom_range(4, 64);
				rx_mode = rx_pace_e'($urandom_range(0, 3));
			end else begin
				seg_left--;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (rx_mode)
					RX_FLOW:  out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:  out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// ---- result checker ----
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				report_mismatch("unexpected result beat", out_data, 0);
			end else begin : compare
				out_item_t want;
				want = results_due.pop_front();
				if (out_data.result_kind !== want.result_kind)
					report_mismatch("result_kind", out_data.result_kind, want.result_kind);
				if (out_data.name_byte !== want.name_byte)
					report_mismatch("name_byte", out_data.name_byte, want.name_byte);
				if (out_data.name_last !== want.name_last)
					report_mismatch("name_last", out_data.name_last, want.name_last);
				if (out_data.host_found !== want.host_found)
					report_mismatch("host_found", out_data.host_found, want.host_found);
				if (out_data.hello_seen !== want.hello_seen)
					report_mismatch("hello_seen", out_data.hello_seen, want.hello_seen);
				if (out_data.name_length !== want.name_length)
					report_mismatch("name_length", out_data.name_length, want.name_length);
				if (want.result_kind == KIND_NAME) begin
					names_seen++;
				end else begin
					verdicts_seen++;
					if (want.host_found) finds_seen++;
				end
			end
		end
	end

	// ---- watchdog ----
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out with %0d results outstanding", results_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// ---- stimulus helpers ----
	task automatic put16(ref octets_t q, input int unsigned v);
		q.push_back(8'(v >> 8));
		q.push_back(8'(v));
	endtask

	task automatic send_payload(input octets_t m, input int unsigned declared);
		in_item_t it;
		for (int k = 0; k < m.size(); k++) begin
			it.data_byte = m[k];
			it.packet_first = (k == 0);
			it.payload_length = (k == 0) ? 16'(declared) : 16'($urandom);
			bytes_to_send.push_back(it);
		end
		items_queued += m.size();
		phase_bytes += (declared == 0) ? 1 : ((declared < m.size()) ? declared : m.size());
		payloads_sent++;
	endtask

	// Beats with no payload open; the block should drop them
	task automatic send_stray(input int unsigned n);
		in_item_t it;
		repeat (n) begin
			it.data_byte = 8'($urandom);
			it.packet_first = 1'b0;
			it.payload_length = 16'($urandom);
			bytes_to_send.push_back(it);
		end
		items_queued += n;
	endtask

	task automatic add_other_ext(ref octets_t q);
		int unsigned k;
		put16(q, $urandom_range(1, 65535));
		k = $urandom_range(0, 6);
		put16(q, k);
		repeat (k) q.push_back(8'($urandom));
	endtask

	// Well-formed ClientHello with random content
	task automatic build_hello(output octets_t m, input int unsigned host_len,
			input bit sni_on, input bit exts_on);
		octets_t body, exts, list;
		int unsigned k;
		body = {};
		exts = {};
		list = {};
		repeat ($urandom_range(0, 2)) add_other_ext(exts);
		if (sni_on) begin
			// sometimes a non-host entry ahead of the host name
			if ($urandom_range(0, 4) == 0) begin
				list.push_back(8'($urandom_range(1, 255)));
				k = $urandom_range(0, 4);
				put16(list, k);
				repeat (k) list.push_back(8'($urandom));
			end
			list.push_back(8'h00);
			put16(list, host_len);
			repeat (host_len) list.push_back(8'($urandom));
			put16(exts, 0);
			put16(exts, list.size() + 2);
			put16(exts, list.size());
			exts = {exts, list};
		end
		repeat ($urandom_range(0, 1)) add_other_ext(exts);

		put16(body, 16'h0303);
		repeat (RANDOM_LEN) body.push_back(8'($urandom));
		k = $urandom_range(0, 32);
		body.push_back(8'(k));
		repeat (k) body.push_back(8'($urandom));
		k = 2 * $urandom_range(1, 4);
		put16(body, k);
		repeat (k) body.push_back(8'($urandom));
		k = $urandom_range(1, 2);
		body.push_back(8'(k));
		repeat (k) body.push_back(8'($urandom));
		if (exts_on) begin
			put16(body, exts.size());
			body = {body, exts};
		end

		m = {};
		m.push_back(TLS_HANDSHAKE);
		m.push_back(TLS_MAJOR);
		m.push_back(8'($urandom_range(0, 4)));
		put16(m, body.size() + 4);
		m.push_back(HS_CLIENT_HELLO);
		m.push_back(8'(body.size() >> 16));
		put16(m, body.size());
		m = {m, body};
		repeat ($urandom_range(0, 2)) m.push_back(8'($urandom));
	endtask

	task automatic queue_random_payload();
		octets_t m;
		int unsigned declared, p;
		int unsigned len_pos[6];
		damage_e dmg;
		len_pos = '{3, 4, 6, 7, 8, 43};
		if ($urandom_range(0, 9) == 0) begin
			// junk that is not TLS at all
			m = {};
			repeat ($urandom_range(1, 12)) m.push_back(8'($urandom));
			declared = ($urandom_range(0, 5) == 0) ? 0 : m.size();
		end else begin
			build_hello(m,
				($urandom_range(0, 19) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 20),
				$urandom_range(0, 9) != 0, $urandom_range(0, 19) != 0);
			declared = m.size();
			if ($urandom_range(0, 99) < 30) begin
				dmg = damage_e'($urandom_range(0, 4));
				case (dmg)
					DMG_BYTE: begin
						p = $urandom_range(0, m.size() - 1);
						m[p] = 8'($urandom);
					end
					DMG_LENGTH: begin
						p = len_pos[$urandom_range(0, 5)];
						m[p] = m[p] ^ 8'(1 << $urandom_range(0, 7));
					end
					DMG_HS_HUGE: m[6] = 8'($urandom_range(1, 255));
					DMG_SHORT: declared = $urandom_range(1, m.size() - 1);
					default: declared = $urandom_range(m.size() + 1, 65535);
				endcase
			end
		end
		send_payload(m, declared);
		if ($urandom_range(0, 9) == 0) send_stray($urandom_range(1, 3));
	endtask

	task automatic wait_drained();
		while (items_accepted != items_queued || results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write then read-back of name_limit
	task automatic set_name_limit(input logic [7:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (pready !== 1'b1) report_mismatch("pready on write", pready, 1);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== v) report_mismatch("name_limit read-back", prdata[7:0], v);
		psel <= 1'b0;
		penable <= 1'b0;
		limit_cfg = v;
	endtask

	// ---- main sequence ----
	initial begin : stimulus
		octets_t m;
		logic [7:0] limit_plan[7];
		limit_cfg = NAME_LIMIT_RST;
		clear_parse();
		limit_plan = '{8'd255, 8'd1, 8'd0, 8'd255, 8'd5,
			8'($urandom_range(2, 254)), 8'($urandom_range(2, 254))};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: short payloads and header edge cases
		send_payload({8'hFF}, 0);
		send_stray(1);
		send_payload({TLS_HANDSHAKE}, 1);
		send_payload({TLS_HANDSHAKE, TLS_MAJOR, 8'h01, 8'h00, 8'h04, HS_CLIENT_HELLO}, 6);
		send_payload({TLS_HANDSHAKE, TLS_MAJOR, 8'h03, 8'h00}, 16'hFFFF);
		send_payload({8'h17, TLS_MAJOR, 8'h03, 8'h00, 8'h05, HS_CLIENT_HELLO, 8'h00}, 7);
		send_payload({TLS_HANDSHAKE, 8'h02, 8'h01, 8'h00, 8'h00}, 5);
		send_payload({8'h00, 8'hFF}, 2);

		// full hellos for the name-related corner cases
		build_hello(m, 0, 1'b1, 1'b1);
		send_payload(m, m.size());
		build_hello(m, 6, 1'b0, 1'b1);
		send_payload(m, m.size());
		build_hello(m, 6, 1'b1, 1'b0);
		send_payload(m, m.size());
		build_hello(m, 6, 1'b1, 1'b1);
		m[6] = 8'h01;
		send_payload(m, m.size());
		build_hello(m, 300, 1'b1, 1'b1);
		send_payload(m, m.size());

		for (int ph = 0; ph < 7; ph++) begin
			if (ph != 0) set_name_limit(limit_plan[ph]);
			phase_bytes = 0;
			build_hello(m, 12, 1'b1, 1'b1);
			send_payload(m, m.size());
			while (phase_bytes < PHASE_MIN) queue_random_payload();
			// close any payload left open
			send_payload({8'h5A}, 0);
			if (ph == 3) begin
				@(posedge clk);
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			parsed_bytes += phase_bytes;
			wait_drained();
		end

		$display("Covered %0d payloads (%0d parsed bytes) over %0d name limit settings.",
			payloads_sent, parsed_bytes, 7);
		$display("Checked %0d host name bytes and %0d verdicts, %0d with a name found.",
			names_seen, verdicts_seen, finds_seen);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
